// ===== rtl/prmq_pkg.sv =====
// Package for the posted receive match queue.
// Shared types and status codes; no dependencies.
package prmq_pkg;

  typedef enum logic [1:0] {
    ST_POSTED  = 2'd0,
    ST_FULL    = 2'd1,
    ST_MATCHED = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_SHIFT,
    S_SHIFT_WR,
    S_OUT
  } state_t;

  // Entry payload as stored in memory.
  typedef struct packed {
    logic [63:0] addr;
    logic [31:0] size;
    logic [63:0] bits;
    logic [63:0] mask;
    logic [63:0] tag;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load;      // capture request
    logic post_wr;   // write request as entry at tail
    logic scan_clr;  // scan pointer to zero
    logic scan_inc;  // advance scan pointer; RAM reads at it every cycle
    logic mv_wr;     // write read data at scan pointer - 2
    logic cnt_inc;
    logic cnt_dec;
    logic set_match; // build matched result
    logic set_post;
    logic set_full;
    logic set_nomatch;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic full;
    logic scan_end;  // scan pointer == count
    logic hit;       // read entry matches
  } sts_t;

endpackage

// ===== rtl/prmq_if.sv =====
// Valid/ready channel interface for the match queue.
// Depends on nothing.
interface prmq_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] buffer_addr;
  logic [31:0] buffer_size;
  logic [63:0] post_bits;
  logic [63:0] post_mask;
  logic [63:0] post_tag;
  logic [31:0] arrival_len;
  logic [63:0] arrival_bits;
  modport source (output valid, mode, buffer_addr, buffer_size, post_bits, post_mask,
                  post_tag, arrival_len, arrival_bits, input ready);
  modport sink (input valid, mode, buffer_addr, buffer_size, post_bits, post_mask,
                post_tag, arrival_len, arrival_bits, output ready);
endinterface

interface prmq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] delivered_len;
  logic [63:0] delivered_bits;
  logic [63:0] delivered_tag;
  logic [63:0] delivered_addr;
  modport source (output valid, status, delivered_len, delivered_bits, delivered_tag,
                  delivered_addr, input ready);
  modport sink (input valid, status, delivered_len, delivered_bits, delivered_tag,
                delivered_addr, output ready);
endinterface

// ===== rtl/prmq_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module prmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/prmq_ctrl.sv =====
// Controller FSM for the match queue.
// Depends on prmq_pkg.
module prmq_ctrl import prmq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_SCAN;
      S_SCAN: begin
        if (!sts.mode || sts.scan_end) state_nxt = S_OUT;
        else state_nxt = S_CHECK;
      end
      S_CHECK:    state_nxt = sts.hit ? S_SHIFT : S_SCAN;
      S_SHIFT:    state_nxt = sts.scan_end ? S_OUT : S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = S_SHIFT;
      S_OUT:      if (out_ready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);
    unique case (state_r)
      S_IDLE: begin
        cmd.load     = in_valid;
        cmd.scan_clr = in_valid;
      end
      S_SCAN: begin
        if (!sts.mode) begin
          cmd.set_full = sts.full;
          cmd.set_post = !sts.full;
          cmd.post_wr  = !sts.full;
          cmd.cnt_inc  = !sts.full;
        end else if (sts.scan_end) begin
          cmd.set_nomatch = 1'b1;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_CHECK: begin
        cmd.set_match = sts.hit;
      end
      S_SHIFT: begin
        if (sts.scan_end) begin
          cmd.cnt_dec = 1'b1;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_SHIFT_WR: cmd.mv_wr = 1'b1;
      S_OUT: ;
      default: ;
    endcase
  end
endmodule

// ===== rtl/prmq_dp.sv =====
// Datapath: entry memory, count, scan pointer and result register.
// Depends on prmq_pkg and prmq_ram.
module prmq_dp import prmq_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        in_mode,
  input  logic [63:0] in_buffer_addr,
  input  logic [31:0] in_buffer_size,
  input  logic [63:0] in_post_bits,
  input  logic [63:0] in_post_mask,
  input  logic [63:0] in_post_tag,
  input  logic [31:0] in_arrival_len,
  input  logic [63:0] in_arrival_bits,
  output logic [1:0]  out_status,
  output logic [31:0] out_delivered_len,
  output logic [63:0] out_delivered_bits,
  output logic [63:0] out_delivered_tag,
  output logic [63:0] out_delivered_addr
);
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  logic           mode_r;
  entry_t         req_r;
  logic [31:0]    alen_r;
  logic [63:0]    abits_r;
  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  ptr_r;
  entry_t         rdata;
  logic           we;
  logic [AW-1:0]  waddr;
  entry_t         wdata;
  logic [CW-1:0]  ptr_m1;
  logic [63:0]    care;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      req_r   <= '{in_buffer_addr, in_buffer_size, in_post_bits, in_post_mask,
                   in_post_tag};
      alen_r  <= in_arrival_len;
      abits_r <= in_arrival_bits;
    end
    if (cmd.scan_clr) begin
      ptr_r <= '0;
    end else if (cmd.scan_inc) begin
      ptr_r <= ptr_r + 1'b1;
    end
  end

  assign ptr_m1 = ptr_r - 1'b1;
  assign we     = cmd.post_wr || cmd.mv_wr;
  // Shift-down write goes one slot below the entry just read.
  assign waddr  = cmd.post_wr ? cnt_r[AW-1:0] : ptr_m1[AW-1:0] - 1'b1;
  assign wdata  = cmd.post_wr ? req_r : rdata;

  prmq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ptr_r[AW-1:0]),
    .rdata (rdata)
  );

  assign care = ~rdata.mask;
  assign sts.mode     = mode_r;
  assign sts.full     = (cnt_r == DEPTH_C);
  assign sts.scan_end = (ptr_r == cnt_r);
  assign sts.hit      = ((rdata.bits & care) == (abits_r & care));

  always_ff @(posedge clk) begin
    if (cmd.set_post || cmd.set_full || cmd.set_nomatch) begin
      out_status         <= cmd.set_post ? ST_POSTED :
                            (cmd.set_full ? ST_FULL : ST_NOMATCH);
      out_delivered_len  <= '0;
      out_delivered_bits <= '0;
      out_delivered_tag  <= '0;
      out_delivered_addr <= '0;
    end else if (cmd.set_match) begin
      out_status         <= ST_MATCHED;
      out_delivered_len  <= (alen_r > rdata.size) ? rdata.size : alen_r;
      out_delivered_bits <= abits_r;
      out_delivered_tag  <= rdata.tag;
      out_delivered_addr <= rdata.addr;
    end
  end
endmodule

// ===== rtl/posted_receive_match_queue.sv =====
// Top level of the posted receive match queue.
// Depends on prmq_pkg, prmq_if, prmq_ctrl, prmq_dp, prmq_ram.
//
//  channel | direction | contents
//  in_     | sink      | post (mode 0) or arrival (mode 1) request
//  out_    | source    | one result per request: status and delivery
//
// Post: a request goes through the idle, scan and out states, its result
// registered in scan. Arrival: each entry up to the hit goes through scan
// and check, then each younger entry is moved down through shift and
// shift-write, all bound by the single read port of the entry RAM.
// Synchronous active-low reset empties the queue; RAM is not cleared.
// A held result stalls the block; no new request is taken until it leaves.
module posted_receive_match_queue import prmq_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input logic       clk,
  input logic       rst_n,
  prmq_in_if.sink   in_ch,
  prmq_out_if.source out_ch
);
  cmd_t cmd;
  sts_t sts;

  prmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  prmq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_mode            (in_ch.mode),
    .in_buffer_addr     (in_ch.buffer_addr),
    .in_buffer_size     (in_ch.buffer_size),
    .in_post_bits       (in_ch.post_bits),
    .in_post_mask       (in_ch.post_mask),
    .in_post_tag        (in_ch.post_tag),
    .in_arrival_len     (in_ch.arrival_len),
    .in_arrival_bits    (in_ch.arrival_bits),
    .out_status         (out_ch.status),
    .out_delivered_len  (out_ch.delivered_len),
    .out_delivered_bits (out_ch.delivered_bits),
    .out_delivered_tag  (out_ch.delivered_tag),
    .out_delivered_addr (out_ch.delivered_addr)
  );
endmodule

// ===== tb/posted_receive_match_queue_test.sv =====
// Testbench for the posted receive match queue: directed and random posts and
// arrivals, checked against an in-bench queue predictor. Depends on prmq_pkg, prmq_if.
module posted_receive_match_queue_test;
  import prmq_pkg::*;

  localparam int DEPTH = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  prmq_in_if  in_ch();
  prmq_out_if out_ch();

  posted_receive_match_queue #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] len;
    logic [63:0] bits;
    logic [63:0] tag;
    logic [63:0] addr;
  } delivery_t;

  // predictor copy of the posted entries, oldest at index 0
  entry_t posted_q[$];
  delivery_t delivery_q[$];
  int errors = 0;
  bit hold_off = 1'b0;   // receiver long stall
  bit no_idle = 1'b0;    // stretches without idling

  initial begin
    in_ch.valid = 1'b0; in_ch.mode = 1'b0; in_ch.buffer_addr = '0; in_ch.buffer_size = '0;
    in_ch.post_bits = '0; in_ch.post_mask = '0; in_ch.post_tag = '0;
    in_ch.arrival_len = '0; in_ch.arrival_bits = '0; out_ch.ready = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Work out the delivery one request causes and update the queue copy.
  function automatic delivery_t predict_delivery(logic mode, entry_t e,
                                                 logic [31:0] alen, logic [63:0] abits);
    delivery_t d;
    logic [63:0] care;
    d = '0;
    if (!mode) begin
      if (posted_q.size() >= DEPTH) d.status = ST_FULL;
      else begin
        posted_q.insert(posted_q.size(), e);
        d.status = ST_POSTED;
      end
      return d;
    end
    d.status = ST_NOMATCH;
    foreach (posted_q[i]) begin
      care = ~posted_q[i].mask;
      if ((posted_q[i].bits & care) == (abits & care)) begin
        d.status = ST_MATCHED;
        d.len = (alen > posted_q[i].size) ? posted_q[i].size : alen;
        d.bits = abits;
        d.tag = posted_q[i].tag;
        d.addr = posted_q[i].addr;
        posted_q.delete(i);
        break;
      end
    end
    return d;
  endfunction

  // Valid stays high after an accept; a later gap or drain() drops it.
  task automatic send_request(logic mode, entry_t e, logic [31:0] alen, logic [63:0] abits);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.buffer_addr <= e.addr; in_ch.buffer_size <= e.size;
    in_ch.post_bits <= e.bits; in_ch.post_mask <= e.mask; in_ch.post_tag <= e.tag;
    in_ch.arrival_len <= alen; in_ch.arrival_bits <= abits;
    do @(posedge clk); while (!in_ch.ready);
    delivery_q.insert(delivery_q.size(), predict_delivery(mode, e, alen, abits));
  endtask

  task automatic post(logic [63:0] a, logic [31:0] s, logic [63:0] b, logic [63:0] m,
                      logic [63:0] t);
    entry_t e;
    e.addr = a; e.size = s; e.bits = b; e.mask = m; e.tag = t;
    send_request(1'b0, e, 32'd0, 64'd0);
  endtask

  task automatic arrive(logic [31:0] l, logic [63:0] b);
    send_request(1'b1, entry_t'(0), l, b);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (delivery_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, long hold-off on request.
  initial begin
    int wait_n;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      wait_n = no_idle ? 0 : $urandom_range(0, 11);
      if (wait_n != 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Result checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    delivery_t x;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (delivery_q.size() == 0) begin
        $display("%0t: unexpected result status %0d", $time, out_ch.status);
        errors++;
      end else begin
        x = delivery_q.pop_front();
        if (out_ch.status !== x.status) begin
          $display("%0t: status exp %0d got %0d", $time, x.status, out_ch.status);
          errors++;
        end
        if (out_ch.delivered_len !== x.len) begin
          $display("%0t: len exp %h got %h", $time, x.len, out_ch.delivered_len);
          errors++;
        end
        if (out_ch.delivered_bits !== x.bits) begin
          $display("%0t: bits exp %h got %h", $time, x.bits, out_ch.delivered_bits);
          errors++;
        end
        if (out_ch.delivered_tag !== x.tag) begin
          $display("%0t: tag exp %h got %h", $time, x.tag, out_ch.delivered_tag);
          errors++;
        end
        if (out_ch.delivered_addr !== x.addr) begin
          $display("%0t: addr exp %h got %h", $time, x.addr, out_ch.delivered_addr);
          errors++;
        end
      end
    end
  end

  // Extremes, empty queue, multiple hits, truncation.
  task automatic test_directed();
    arrive(32'hFFFF_FFFF, '1);                     // empty queue
    post('1, 32'hFFFF_FFFF, '1, 64'd0, '1);
    post(64'd0, 32'd0, 64'd0, 64'd0, 64'd0);
    post(64'h1234, 32'd10, 64'hAA, '1, 64'h55);     // matches anything
    post(64'h5678, 32'd100, 64'hAA, 64'h0F, 64'h66);
    arrive(32'd50, 64'hA5);                        // misses first two, hits mask-all
    arrive(32'd0, 64'd0);                          // exact zero entry
    arrive(32'd500, 64'hA3);                       // hits masked entry, truncated
    arrive(32'h1, '1);                             // all-ones entry
    arrive(32'd7, 64'h1);                          // no match
    drain();
  endtask

  // Fill the queue to its depth, post into a full queue, then take entries out by arrivals.
  task automatic test_full_queue();
    for (int i = 0; i < DEPTH + 3; i++)
      post(rand64(), $urandom(), 64'(i), 64'd0, rand64());
    for (int i = DEPTH - 1; i >= 0; i -= 7) arrive($urandom(), 64'(i));
    arrive($urandom(), 64'hDEAD);
    drain();
    for (int i = 0; i < DEPTH; i++) arrive($urandom(), rand64() | 64'hFFFF_0000_0000_0000);
    repeat (2) arrive($urandom(), '1);
    post('0, '0, '0, '1, '0);
    drain();
    repeat (200) arrive(32'd0, rand64());  // first takes the catch-all entry
    drain();
  endtask

  // Receiver holds off long while the sender keeps offering.
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 40; i++) post(rand64(), $urandom(), rand64(), rand64(), rand64());
    drain();
    for (int i = 0; i < 40; i++) arrive($urandom(), rand64());
    drain();
  endtask

  // Random mix: bits mostly in a small range so arrivals hit, random masks and noise.
  task automatic test_random();
    logic [63:0] b, m;
    for (int n = 0; n < 1600; n++) begin
      if (n == 800) no_idle = 1'b1;
      if (n == 1100) no_idle = 1'b0;
      if (n % 400 == 399) drain();
      b = rand64();
      if ($urandom_range(0, 3) != 0) b[63:3] = '0;
      m = ($urandom_range(0, 3) == 0) ? rand64() : 64'd0;
      if (posted_q.size() > 48 || $urandom_range(0, 1)) arrive($urandom(), b);
      else post(rand64(), $urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom(),
                b, m, rand64());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_queue();
    test_backpressure();
    test_random();
    drain();
    repeat (300) @(posedge clk);
    if (errors == 0 && delivery_q.size() == 0) begin
      $display("posted_receive_match_queue_test passed");
    end else begin
      $display("posted_receive_match_queue_test failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("posted_receive_match_queue_test failed");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/prmq_pkg.sv
rtl/prmq_if.sv
rtl/prmq_ram.sv
rtl/prmq_ctrl.sv
rtl/prmq_dp.sv
rtl/posted_receive_match_queue.sv
tb/posted_receive_match_queue_test.sv
